[rtl/clipped_rect_fill_engine_core_assert.svh]
// Assertion macros used by the fill engine core.
`ifndef CLIPPED_RECT_FILL_ENGINE_CORE_ASSERT_SVH
`define CLIPPED_RECT_FILL_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRFE_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crfe check failed");

// Next-cycle implication, checked outside reset.
`define CRFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crfe check failed");

`endif

[rtl/crfe_pkg.sv]
// Shared constants for the clipped rectangle fill engine.
package crfe_pkg;

   localparam int CRFE_COORD_BITS = 16;
   localparam int OFFSET_BITS     = 32;
   localparam int COLOR_BITS      = 32;
   localparam int KIND_BITS       = 2;
   localparam int REG_INDEX_BITS  = 3;

   // request selector
   localparam logic FUNC_FILL = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // response kinds
   localparam logic [KIND_BITS-1:0] KIND_REPORT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_PIXEL  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_IDLE   = 2'd2;

   // register indexes
   localparam logic [REG_INDEX_BITS-1:0] REG_CLIP_ENABLE   = 3'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_CLIP_LEFT     = 3'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_CLIP_TOP      = 3'd2;
   localparam logic [REG_INDEX_BITS-1:0] REG_CLIP_WIDTH    = 3'd3;
   localparam logic [REG_INDEX_BITS-1:0] REG_CLIP_HEIGHT   = 3'd4;
   localparam logic [REG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd5;
   localparam logic [REG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd6;
   localparam logic [REG_INDEX_BITS-1:0] REG_LINE_PITCH    = 3'd7;

endpackage

[rtl/clipped_rect_fill_engine_core.sv]
// Clipped solid rectangle fill engine: command clipping and pixel write stream.
// A request word waits in the request register; when the response register can
// advance, the word computed from it is loaded there. Throughput: one word per
// cycle unless rsp_tready stalls it, one pixel write per tick; clip, multiply
// and offset add each sit between the two registers. Reset (synchronous, active
// high) clears the configuration registers, drops busy, empties both registers.
`include "clipped_rect_fill_engine_core_assert.svh"

module clipped_rect_fill_engine_core
   import crfe_pkg::*;
#(
   parameter int COORD_BITS = CRFE_COORD_BITS
) (
   input  logic                                           clock,
   input  logic                                           reset,
   // csr write port
   input  logic                                           csr_wr_en,
   input  logic [REG_INDEX_BITS-1:0]                      csr_index,
   input  logic [COORD_BITS-1:0]                          csr_wdata,
   // request stream
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // tdata: rect_x, rect_y, rect_width, rect_height, fill_color
   input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0]   req_tdata,
   // tuser: func
   input  logic                                           req_tuser,
   // response stream
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // tdata: accepted, pixel_offset, pixel_color, dirty_x, dirty_y,
   //        dirty_width, dirty_height
   output logic [((1+OFFSET_BITS+COLOR_BITS+4*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // tuser: kind
   output logic [KIND_BITS-1:0]                           rsp_tuser,
   output logic                                           rsp_tlast
);

   localparam int C             = COORD_BITS;
   localparam int REQ_DATA_BITS = ((4*COORD_BITS+COLOR_BITS+7)/8)*8;
   localparam int RSP_FIELDS    = 1+OFFSET_BITS+COLOR_BITS+4*COORD_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELDS+7)/8)*8;
   localparam int PROD_BITS     = (2*COORD_BITS > OFFSET_BITS) ? 2*COORD_BITS : OFFSET_BITS;

   typedef struct packed {
      logic         ok;
      logic [C-1:0] pos;
      logic [C-1:0] len;
   } axis_type;

   // Clip one axis against [lo, hi); ok drops when nothing is left.
   function automatic axis_type clip_axis(input logic [C-1:0] pos,
                                          input logic [C-1:0] len,
                                          input logic [C:0]   lo,
                                          input logic [C:0]   hi);
      axis_type   res;
      logic       ok;
      logic [C:0] p;
      logic [C:0] l;
      logic [C:0] skip;
      ok   = 1'b1;
      p    = {1'b0, pos};
      l    = {1'b0, len};
      skip = '0;
      if (p >= hi) begin
         ok = 1'b0;
      end
      if (p < lo) begin
         skip = lo - p;
         if (skip >= l) begin
            ok = 1'b0;
         end else begin
            l = l - skip;
         end
         p = lo;
      end
      if ((C+2)'(p) + (C+2)'(l) > (C+2)'(hi)) begin
         l = hi - p;
      end
      res.ok  = ok && (l != '0);
      res.pos = p[C-1:0];
      res.len = l[C-1:0];
      return res;
   endfunction

   // configuration
   logic         clip_enable_ff;
   logic [C-1:0] clip_left_ff, clip_top_ff, clip_width_ff, clip_height_ff;
   logic [C-1:0] screen_width_ff, screen_height_ff, line_pitch_ff;

   // request register
   logic                     s1_vld_ff;
   logic                     s1_func_ff;
   logic [REQ_DATA_BITS-1:0] s1_data_ff;

   // fill state
   logic                   busy_ff, busy_in;
   logic [C-1:0]           fill_left_ff, fill_left_in;
   logic [C-1:0]           fill_cols_ff, fill_cols_in;
   logic [C-1:0]           fill_rows_ff, fill_rows_in;
   logic [C-1:0]           row_count_ff, row_count_in;
   logic [C-1:0]           col_count_ff, col_count_in;
   logic [OFFSET_BITS-1:0] row_start_ff, row_start_in;
   logic [COLOR_BITS-1:0]  held_color_ff, held_color_in;

   // response register
   logic                     rsp_vld_ff;
   logic [KIND_BITS-1:0]     rsp_kind_ff, rsp_kind_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                   advance;
   logic                   step;
   logic [C-1:0]           rx, ry, rw, rh;
   logic [COLOR_BITS-1:0]  rcolor;
   axis_type               win_x, win_y, scr_x, scr_y;
   logic [C-1:0]           x1, y1, w1, h1;
   logic                   base_ok, win_ok, fill_ok;
   logic [PROD_BITS-1:0]   row_prod;
   logic                   col_last, row_last;
   logic                   accepted_in;
   logic [OFFSET_BITS-1:0] offset_in;
   logic [COLOR_BITS-1:0]  color_in;
   logic [C-1:0]           dx_in, dy_in, dw_in, dh_in;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || advance;
   assign step       = s1_vld_ff && advance;

   assign rx     = s1_data_ff[C-1:0];
   assign ry     = s1_data_ff[2*C-1:C];
   assign rw     = s1_data_ff[3*C-1:2*C];
   assign rh     = s1_data_ff[4*C-1:3*C];
   assign rcolor = s1_data_ff[4*C+COLOR_BITS-1:4*C];

   // clip window first, then the screen
   assign win_x = clip_axis(rx, rw, {1'b0, clip_left_ff},
                            (C+1)'(clip_left_ff) + (C+1)'(clip_width_ff));
   assign win_y = clip_axis(ry, rh, {1'b0, clip_top_ff},
                            (C+1)'(clip_top_ff) + (C+1)'(clip_height_ff));

   assign win_ok = !clip_enable_ff || (win_x.ok && win_y.ok);
   assign x1     = clip_enable_ff ? win_x.pos : rx;
   assign y1     = clip_enable_ff ? win_y.pos : ry;
   assign w1     = clip_enable_ff ? win_x.len : rw;
   assign h1     = clip_enable_ff ? win_y.len : rh;

   assign scr_x = clip_axis(x1, w1, '0, {1'b0, screen_width_ff});
   assign scr_y = clip_axis(y1, h1, '0, {1'b0, screen_height_ff});

   assign base_ok  = (rw != '0) && (rh != '0) && (line_pitch_ff != '0);
   assign fill_ok  = base_ok && win_ok && scr_x.ok && scr_y.ok;
   assign row_prod = PROD_BITS'(scr_y.pos) * PROD_BITS'(line_pitch_ff);

   assign col_last = col_count_ff == fill_cols_ff - 1'b1;
   assign row_last = row_count_ff == fill_rows_ff - 1'b1;

   always_comb begin
      busy_in       = busy_ff;
      fill_left_in  = fill_left_ff;
      fill_cols_in  = fill_cols_ff;
      fill_rows_in  = fill_rows_ff;
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      row_start_in  = row_start_ff;
      held_color_in = held_color_ff;
      rsp_kind_in   = KIND_IDLE;
      rsp_last_in   = 1'b0;
      accepted_in   = 1'b0;
      offset_in     = '0;
      color_in      = '0;
      dx_in         = '0;
      dy_in         = '0;
      dw_in         = '0;
      dh_in         = '0;
      if (s1_func_ff == FUNC_FILL) begin
         // a new command drops any fill in progress
         rsp_kind_in = KIND_REPORT;
         busy_in     = fill_ok;
         if (fill_ok) begin
            fill_left_in  = scr_x.pos;
            fill_cols_in  = scr_x.len;
            fill_rows_in  = scr_y.len;
            row_count_in  = '0;
            col_count_in  = '0;
            row_start_in  = row_prod[OFFSET_BITS-1:0];
            held_color_in = rcolor;
            accepted_in   = 1'b1;
            dx_in         = scr_x.pos;
            dy_in         = scr_y.pos;
            dw_in         = scr_x.len;
            dh_in         = scr_y.len;
         end
      end else if (busy_ff) begin
         rsp_kind_in  = KIND_PIXEL;
         offset_in    = row_start_ff + OFFSET_BITS'(fill_left_ff) +
                        OFFSET_BITS'(col_count_ff);
         color_in     = held_color_ff;
         rsp_last_in  = col_last && row_last;
         col_count_in = col_count_ff + 1'b1;
         if (col_last) begin
            col_count_in = '0;
            row_count_in = row_count_ff + 1'b1;
            row_start_in = row_start_ff + OFFSET_BITS'(line_pitch_ff);
            busy_in      = !row_last;
         end
      end
      rsp_data_in = RSP_DATA_BITS'({dh_in, dw_in, dy_in, dx_in,
                                    color_in, offset_in, accepted_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_enable_ff   <= 1'b0;
         clip_left_ff     <= '0;
         clip_top_ff      <= '0;
         clip_width_ff    <= '0;
         clip_height_ff   <= '0;
         screen_width_ff  <= '0;
         screen_height_ff <= '0;
         line_pitch_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_CLIP_ENABLE:   clip_enable_ff   <= csr_wdata[0];
            REG_CLIP_LEFT:     clip_left_ff     <= csr_wdata;
            REG_CLIP_TOP:      clip_top_ff      <= csr_wdata;
            REG_CLIP_WIDTH:    clip_width_ff    <= csr_wdata;
            REG_CLIP_HEIGHT:   clip_height_ff   <= csr_wdata;
            REG_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            REG_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            REG_LINE_PITCH:    line_pitch_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_func_ff <= req_tuser;
         s1_data_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (step) begin
            busy_ff <= busy_in;
         end
         if (advance) begin
            rsp_vld_ff <= s1_vld_ff;
         end
      end
   end

   // advance fill state and load the response word
   always_ff @(posedge clock) begin
      if (step) begin
         fill_left_ff  <= fill_left_in;
         fill_cols_ff  <= fill_cols_in;
         fill_rows_ff  <= fill_rows_in;
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         row_start_ff  <= row_start_in;
         held_color_ff <= held_color_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

   `CRFE_ASSERT_NEXT(a_idle_tick, clock, reset,
      step && (s1_func_ff == FUNC_TICK) && !busy_ff, rsp_kind_ff == KIND_IDLE)
   `CRFE_ASSERT_HOLDS(a_last_ends_fill, clock, reset,
      rsp_vld_ff && (rsp_kind_ff == KIND_PIXEL) && rsp_last_ff, !busy_ff)
   `CRFE_ASSERT_HOLDS(a_report_matches_busy, clock, reset,
      rsp_vld_ff && (rsp_kind_ff == KIND_REPORT), busy_ff == rsp_data_ff[0])
   `CRFE_ASSERT_HOLDS(a_counts_in_range, clock, reset,
      busy_ff, (col_count_ff < fill_cols_ff) && (row_count_ff < fill_rows_ff))

endmodule

[bench/tb_clipped_rect_fill_engine_core.sv]
// Self-checking testbench for the clipped rectangle fill engine core.
`timescale 1ns / 1ps

module tb_clipped_rect_fill_engine_core;
   import crfe_pkg::*;

   localparam int REQ_W = ((4*CRFE_COORD_BITS+COLOR_BITS+7)/8)*8;
   localparam int RSP_W = ((1+OFFSET_BITS+COLOR_BITS+4*CRFE_COORD_BITS+7)/8)*8;
   localparam int CALM_FROM = 1200;
   localparam int CALM_TO   = 1700;
   localparam int HOLD_CYCLES = 200;

   typedef struct {
      logic        func;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic [31:0] color;
   } fill_word_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 accepted;
      logic [31:0]          offset;
      logic [31:0]          color;
      logic [15:0]          dx;
      logic [15:0]          dy;
      logic [15:0]          dw;
      logic [15:0]          dh;
      logic                 last;
   } fill_result_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [REG_INDEX_BITS-1:0]    csr_index = '0;
   logic [CRFE_COORD_BITS-1:0]   csr_wdata = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_W-1:0]             req_tdata = '0;
   logic                         req_tuser = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_W-1:0]             rsp_tdata;
   logic [KIND_BITS-1:0]         rsp_tuser;
   logic                         rsp_tlast;

   clipped_rect_fill_engine_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // register copy used by the predictor
   bit          cfg_clip_en;
   int unsigned cfg_clip_left, cfg_clip_top, cfg_clip_width, cfg_clip_height;
   int unsigned cfg_screen_w, cfg_screen_h, cfg_line_pitch;

   // fill progress as the predictor sees it
   bit          fill_busy;
   int unsigned fill_left, fill_top, fill_cols, fill_rows, row_idx, col_idx;
   logic [31:0] row_base, held_color;

   fill_word_type   pending_words[$];
   fill_result_type fill_outputs_due[$];
   fill_word_type   word_on_bus;
   int              words_queued;
   int              rsp_count;
   int              next_hold_at = 100;
   int              stall_left;
   int              error_count;
   int              cycle_no;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_no <= cycle_no + 1;

   function automatic bit take_break();
      if (cycle_no >= CALM_FROM && cycle_no < CALM_TO) return 1'b0;
      return $urandom_range(0, 99) < 20;
   endfunction

   // Trim one axis to [lo, hi); false when nothing is left.
   function automatic bit clip_span(inout int unsigned pos, inout int unsigned len,
                                    input int unsigned lo, input int unsigned hi);
      int unsigned skip;
      if (pos >= hi) return 1'b0;
      if (pos < lo) begin
         skip = lo - pos;
         if (skip >= len) return 1'b0;
         len = len - skip;
         pos = lo;
      end
      if (pos + len > hi) len = hi - pos;
      return len != 0;
   endfunction

   task automatic predict_fill_word(input fill_word_type wd);
      fill_result_type r;
      int unsigned     x, y, w, h;
      bit              ok;
      logic [63:0]     addr;
      r = '0;
      if (wd.func == FUNC_FILL) begin
         x = wd.x;
         y = wd.y;
         w = wd.w;
         h = wd.h;
         ok = (w != 0) && (h != 0) && (cfg_line_pitch != 0);
         if (ok && cfg_clip_en)
            ok = clip_span(x, w, cfg_clip_left, cfg_clip_left + cfg_clip_width) &&
                 clip_span(y, h, cfg_clip_top, cfg_clip_top + cfg_clip_height);
         if (ok)
            ok = clip_span(x, w, 0, cfg_screen_w) && clip_span(y, h, 0, cfg_screen_h);
         r.kind = KIND_REPORT;
         fill_busy = ok;
         if (ok) begin
            fill_left  = x;
            fill_top   = y;
            fill_cols  = w;
            fill_rows  = h;
            row_idx    = 0;
            col_idx    = 0;
            row_base   = y * cfg_line_pitch;
            held_color = wd.color;
            r.accepted = 1'b1;
            r.dx = x[15:0];
            r.dy = y[15:0];
            r.dw = w[15:0];
            r.dh = h[15:0];
         end
      end else if (!fill_busy) begin
         r.kind = KIND_IDLE;
      end else begin
         r.kind   = KIND_PIXEL;
         addr     = 64'(row_base) + 64'(fill_left) + 64'(col_idx);
         r.offset = addr[31:0];
         r.color  = held_color;
         r.last   = (col_idx + 1 == fill_cols) && (row_idx + 1 == fill_rows);
         col_idx++;
         if (col_idx >= fill_cols) begin
            col_idx = 0;
            row_idx++;
            row_base = row_base + cfg_line_pitch;
            if (row_idx >= fill_rows) fill_busy = 1'b0;
         end
      end
      fill_outputs_due.push_back(r);
   endtask

   // request side: predict on acceptance, then offer the next word
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_fill_word(word_on_bus);
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() != 0 && !take_break()) begin
               word_on_bus = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= word_on_bus.func;
               req_tdata  <= REQ_W'({word_on_bus.color, word_on_bus.h, word_on_bus.w,
                                     word_on_bus.y, word_on_bus.x});
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side: check each word, stall at random, hold off now and then
   always @(posedge clock) begin : rsp_side
      fill_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind     = rsp_tuser;
            got.accepted = rsp_tdata[0];
            got.offset   = rsp_tdata[32:1];
            got.color    = rsp_tdata[64:33];
            got.dx       = rsp_tdata[80:65];
            got.dy       = rsp_tdata[96:81];
            got.dw       = rsp_tdata[112:97];
            got.dh       = rsp_tdata[128:113];
            got.last     = rsp_tlast;
            rsp_count++;
            if (fill_outputs_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word kind=%0d offset=%h", $realtime,
                        got.kind, got.offset);
            end else begin
               want = fill_outputs_due.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: mismatch expected kind=%0d acc=%0d off=%h col=%h",
                           $realtime, want.kind, want.accepted, want.offset, want.color,
                           " dirty=%0d,%0d,%0d,%0d last=%0d",
                           want.dx, want.dy, want.dw, want.dh, want.last);
                  $display("%0t:          actual kind=%0d acc=%0d off=%h col=%h",
                           $realtime, got.kind, got.accepted, got.offset, got.color,
                           " dirty=%0d,%0d,%0d,%0d last=%0d",
                           got.dx, got.dy, got.dw, got.dh, got.last);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_count >= next_hold_at && pending_words.size() > 50) begin
            // hold off long enough for the engine to back up into its input
            stall_left = HOLD_CYCLES;
            next_hold_at += 700;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !take_break();
         end
      end
   end

   task automatic push_fill(input int unsigned x, input int unsigned y,
                            input int unsigned w, input int unsigned h,
                            input logic [31:0] color);
      fill_word_type wd;
      wd.func  = FUNC_FILL;
      wd.x     = x[15:0];
      wd.y     = y[15:0];
      wd.w     = w[15:0];
      wd.h     = h[15:0];
      wd.color = color;
      pending_words.push_back(wd);
      words_queued++;
   endtask

   task automatic push_ticks(input int unsigned n);
      fill_word_type wd;
      wd.func  = FUNC_TICK;
      wd.x     = 16'($urandom());
      wd.y     = 16'($urandom());
      wd.w     = 16'($urandom());
      wd.h     = 16'($urandom());
      wd.color = $urandom();
      repeat (n) begin
         pending_words.push_back(wd);
         words_queued++;
      end
   endtask

   // Wait until every queued word has come back as a response.
   task automatic wait_idle();
      while (rsp_count != words_queued || fill_outputs_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_INDEX_BITS-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      case (idx)
         REG_CLIP_ENABLE:   cfg_clip_en     = val[0];
         REG_CLIP_LEFT:     cfg_clip_left   = val & 32'hFFFF;
         REG_CLIP_TOP:      cfg_clip_top    = val & 32'hFFFF;
         REG_CLIP_WIDTH:    cfg_clip_width  = val & 32'hFFFF;
         REG_CLIP_HEIGHT:   cfg_clip_height = val & 32'hFFFF;
         REG_SCREEN_WIDTH:  cfg_screen_w    = val & 32'hFFFF;
         REG_SCREEN_HEIGHT: cfg_screen_h    = val & 32'hFFFF;
         REG_LINE_PITCH:    cfg_line_pitch  = val & 32'hFFFF;
         default: ;
      endcase
   endtask

   // Drop any unfinished fill with an empty command, drain, then rewrite all registers.
   task automatic load_config(input int unsigned en, input int unsigned cl,
                              input int unsigned ct, input int unsigned cw,
                              input int unsigned ch, input int unsigned sw,
                              input int unsigned sh, input int unsigned pitch);
      push_fill(0, 0, 0, 0, 0);
      wait_idle();
      write_reg(REG_CLIP_ENABLE, en);
      write_reg(REG_CLIP_LEFT, cl);
      write_reg(REG_CLIP_TOP, ct);
      write_reg(REG_CLIP_WIDTH, cw);
      write_reg(REG_CLIP_HEIGHT, ch);
      write_reg(REG_SCREEN_WIDTH, sw);
      write_reg(REG_SCREEN_HEIGHT, sh);
      write_reg(REG_LINE_PITCH, pitch);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int unsigned pick_extent();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 65535;
      if (r == 2) return $urandom_range(0, 65535);
      return $urandom_range(1, 40);
   endfunction

   function automatic int unsigned pick_origin();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
      return $urandom_range(0, 30);
   endfunction

   // Coordinate a little around [lo, lo+len) so that clipping bites on both sides.
   function automatic int unsigned near_coord(input int unsigned lo, input int unsigned len);
      int v;
      v = int'(lo) - 4 + int'($urandom_range(0, (len > 60 ? 60 : len) + 6));
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v;
   endfunction

   initial begin : stimulus
      int unsigned x, y, w, h, n, r, sw, pitch, span_len;
      int          start, quota;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // pitch is zero out of reset: every command is turned down
      push_fill(65535, 65535, 65535, 65535, 32'hFFFF_FFFF);
      push_ticks(1);

      load_config(0, 0, 0, 0, 0, 16, 12, 16);
      push_fill(0, 0, 1, 1, 32'hFFFF_FFFF);
      push_ticks(2);
      push_fill(5, 5, 0, 3, 32'h1234_5678);
      push_fill(5, 5, 3, 0, 32'h1234_5678);
      // oversize rectangle trimmed to the screen corner
      push_fill(14, 10, 65535, 65535, 32'h0000_0001);
      push_ticks(4);
      push_fill(65535, 0, 1, 1, 32'h0);
      push_ticks(1);
      // second command cuts the first fill short
      push_fill(3, 3, 3, 2, 32'hA5A5_5A5A);
      push_ticks(2);
      push_fill(0, 11, 3, 1, 32'h5A5A_A5A5);
      push_ticks(4);

      load_config(1, 4, 3, 8, 5, 16, 12, 20);
      push_fill(0, 0, 6, 5, 32'hCAFE_F00D);
      push_ticks(4);
      push_fill(0, 0, 4, 3, 32'h0F0F_0F0F);

      for (int p = 0; p < 7; p++) begin
         if (p == 0) begin
            load_config(1, 0, 0, 65535, 65535, 65535, 65535, 65535);
         end else if (p == 1) begin
            load_config(0, 0, 0, 0, 0, 0, 0, 0);
         end else begin
            sw = pick_extent();
            r = $urandom_range(0, 9);
            if (r == 0) pitch = 0;
            else if (r == 1) pitch = $urandom_range(0, 65535);
            else pitch = sw + $urandom_range(0, 20);
            if (pitch > 65535) pitch = 65535;
            load_config($urandom_range(0, 1), pick_origin(), pick_origin(), pick_extent(),
                        pick_extent(), sw, pick_extent(), pitch);
         end
         quota = (p == 1) ? 60 : 260;
         start = words_queued;
         while (words_queued - start < quota) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
               // well-formed fill: command, then about enough ticks to finish it
               if (cfg_clip_en) begin
                  x = near_coord(cfg_clip_left, cfg_clip_width);
                  y = near_coord(cfg_clip_top, cfg_clip_height);
               end else begin
                  x = near_coord(0, cfg_screen_w);
                  y = near_coord(0, cfg_screen_h);
               end
               w = $urandom_range(1, 8);
               h = $urandom_range(1, 6);
               push_fill(x, y, w, h, $urandom());
               span_len = w * h;
               if ($urandom_range(0, 9) < 7) n = span_len + $urandom_range(0, 2);
               else n = $urandom_range(0, span_len);
               push_ticks(n);
            end else if (r == 8) begin
               push_fill($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
               push_ticks($urandom_range(0, 3));
            end else begin
               push_ticks($urandom_range(1, 3));
            end
         end
      end

      wait_idle();
      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_clipped_rect_fill_engine_core: done, clean");
      end else begin
         $display("tb_clipped_rect_fill_engine_core: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb_clipped_rect_fill_engine_core: done, errors");
      $finish;
   end

endmodule
